[design/osrc_pkg.sv]
`default_nettype none

package osrc_pkg;

	// default sizes
	localparam int STACK_DEPTH_DEF  = 128;
	localparam int RECENT_DEPTH_DEF = 10;

	// field widths
	localparam int WORD_W = 64;
	localparam int CMD_W  = 3;
	localparam int IDX_W  = 4;
	localparam int STAT_W = 2;
	localparam int FILL_W = 8;

	// command codes
	localparam logic [CMD_W-1:0] CMD_PUSH   = 3'd0;
	localparam logic [CMD_W-1:0] CMD_POP    = 3'd1;
	localparam logic [CMD_W-1:0] CMD_PEEK   = 3'd2;
	localparam logic [CMD_W-1:0] CMD_DUP    = 3'd3;
	localparam logic [CMD_W-1:0] CMD_SWAP   = 3'd4;
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd5;
	localparam logic [CMD_W-1:0] CMD_RECENT = 3'd6;

	// status codes
	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
	localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;

endpackage

`default_nettype wire

[design/operand_stack_with_recent_cache.sv]
`default_nettype none

// Operand stack of 64-bit words with a store of the words most recently written by push
// or swap. One command enters per beat on the s_ side and gives exactly one result beat
// on the m_ side, held in an output register; the next command is taken once that
// register is empty or its beat leaves at the same edge, and never while a command is
// still in progress. The stack lives in a single-port memory with a registered read:
// push, clear, read_recent, unused codes and refused commands need no read; pop,
// peek and duplicate read the top entry, then act on it; swap reads the top, reads the
// second and writes each back. Entries are never read beyond the fill count, so the
// stack memory needs no clearing after reset.
module operand_stack_with_recent_cache
	import osrc_pkg::*;
#(
	parameter int STACK_DEPTH  = STACK_DEPTH_DEF,
	parameter int RECENT_DEPTH = RECENT_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// push_value [63:0], recent_index [67:64], zero pad [71:68]
	input  wire logic [71:0] s_tdata,
	// command [2:0]
	input  wire logic [2:0]  s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// read_value [63:0], fill_level [71:64]
	output logic      [71:0] m_tdata,
	// status [1:0]
	output logic      [1:0]  m_tuser
);

	localparam int AW  = $clog2(STACK_DEPTH);
	localparam int CW  = $clog2(STACK_DEPTH + 1);
	localparam int RIW = (RECENT_DEPTH > 1) ? $clog2(RECENT_DEPTH) : 1;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_RD1  = 2'd1;
	localparam logic [1:0] S_RD2  = 2'd2;
	localparam logic [1:0] S_WR2  = 2'd3;

	logic [1:0]        state_q, state_nxt;
	logic [CW-1:0]     count_q, cnt_nxt;
	logic [CMD_W-1:0]  cmd_q;
	logic [WORD_W-1:0] a_q, b_q;
	logic [WORD_W-1:0] recent_q [RECENT_DEPTH];

	logic              m_tvalid_q;
	logic [WORD_W-1:0] rv_q;
	logic [STAT_W-1:0] st_q;
	logic [FILL_W-1:0] fill_q;

	logic [CMD_W-1:0]  in_cmd;
	logic [WORD_W-1:0] in_word;
	logic [IDX_W-1:0]  in_idx;
	logic              s_fire;
	logic              full, empty;
	logic [CW-1:0]     top_m1, top_m2;

	logic              mem_en, mem_we;
	logic [AW-1:0]     mem_addr;
	logic [WORD_W-1:0] mem_wdata, mem_rdata;

	logic              out_load;
	logic [WORD_W-1:0] out_rv;
	logic [STAT_W-1:0] out_st;
	logic              shift_en;
	logic [WORD_W-1:0] shift_word;
	logic              a_load, b_load;

	// input unpacking
	assign in_cmd  = s_tuser;
	assign in_word = s_tdata[WORD_W-1:0];
	assign in_idx  = s_tdata[WORD_W+IDX_W-1:WORD_W];

	assign s_tready = (state_q == S_IDLE) && (!m_tvalid_q || m_tready);
	assign s_fire   = s_tvalid && s_tready;

	assign full   = (count_q >= CW'(STACK_DEPTH));
	assign empty  = (count_q == '0);
	assign top_m1 = count_q - CW'(1);
	assign top_m2 = count_q - CW'(2);

	osrc_ram #(
		.DEPTH(STACK_DEPTH),
		.WIDTH(WORD_W)
	) u_ram (
		.clk  (clk),
		.en   (mem_en),
		.we   (mem_we),
		.addr (mem_addr),
		.wdata(mem_wdata),
		.rdata(mem_rdata)
	);

	// command sequencer
	always_comb begin
		state_nxt  = state_q;
		cnt_nxt    = count_q;
		mem_en     = 1'b0;
		mem_we     = 1'b0;
		mem_addr   = '0;
		mem_wdata  = '0;
		out_load   = 1'b0;
		out_rv     = '0;
		out_st     = ST_OK;
		shift_en   = 1'b0;
		shift_word = '0;
		a_load     = 1'b0;
		b_load     = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (s_fire) begin
					case (in_cmd) inside
						CMD_PUSH: begin
							out_load = 1'b1;
							if (full) begin
								out_st = ST_FULL;
							end else begin
								mem_en     = 1'b1;
								mem_we     = 1'b1;
								mem_addr   = count_q[AW-1:0];
								mem_wdata  = in_word;
								cnt_nxt    = count_q + CW'(1);
								shift_en   = 1'b1;
								shift_word = in_word;
							end
						end
						CMD_POP, CMD_PEEK: begin
							if (empty) begin
								out_load = 1'b1;
								out_st   = ST_EMPTY;
							end else begin
								mem_en    = 1'b1;
								mem_addr  = top_m1[AW-1:0];
								state_nxt = S_RD1;
							end
						end
						CMD_DUP: begin
							if (empty) begin
								out_load = 1'b1;
								out_st   = ST_EMPTY;
							end else if (full) begin
								out_load = 1'b1;
								out_st   = ST_FULL;
							end else begin
								mem_en    = 1'b1;
								mem_addr  = top_m1[AW-1:0];
								state_nxt = S_RD1;
							end
						end
						CMD_SWAP: begin
							if (count_q < CW'(2)) begin
								out_load = 1'b1;
								out_st   = ST_EMPTY;
							end else begin
								mem_en    = 1'b1;
								mem_addr  = top_m1[AW-1:0];
								state_nxt = S_RD1;
							end
						end
						CMD_CLEAR: begin
							out_load = 1'b1;
							cnt_nxt  = '0;
						end
						CMD_RECENT: begin
							out_load = 1'b1;
							if ({1'b0, in_idx} < (IDX_W+1)'(RECENT_DEPTH)) begin
								out_rv = recent_q[in_idx[RIW-1:0]];
							end else begin
								out_st = ST_RANGE;
							end
						end
						default: begin
							out_load = 1'b1;
						end
					endcase
				end
			end
			S_RD1: begin
				state_nxt = S_IDLE;
				case (cmd_q)
					CMD_POP: begin
						out_load = 1'b1;
						out_rv   = mem_rdata;
						cnt_nxt  = top_m1;
					end
					CMD_PEEK: begin
						out_load = 1'b1;
						out_rv   = mem_rdata;
					end
					CMD_DUP: begin
						out_load  = 1'b1;
						mem_en    = 1'b1;
						mem_we    = 1'b1;
						mem_addr  = count_q[AW-1:0];
						mem_wdata = mem_rdata;
						cnt_nxt   = count_q + CW'(1);
					end
					CMD_SWAP: begin
						a_load    = 1'b1;
						mem_en    = 1'b1;
						mem_addr  = top_m2[AW-1:0];
						state_nxt = S_RD2;
					end
					default: begin
						out_load = 1'b1;
					end
				endcase
			end
			S_RD2: begin
				// old top goes down, and into the recent store first
				b_load     = 1'b1;
				mem_en     = 1'b1;
				mem_we     = 1'b1;
				mem_addr   = top_m2[AW-1:0];
				mem_wdata  = a_q;
				shift_en   = 1'b1;
				shift_word = a_q;
				state_nxt  = S_WR2;
			end
			S_WR2: begin
				mem_en     = 1'b1;
				mem_we     = 1'b1;
				mem_addr   = top_m1[AW-1:0];
				mem_wdata  = b_q;
				shift_en   = 1'b1;
				shift_word = b_q;
				out_load   = 1'b1;
				state_nxt  = S_IDLE;
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_nxt;
			count_q <= cnt_nxt;
		end
	end

	// command and swap operands
	always_ff @(posedge clk) begin
		if (s_fire) begin
			cmd_q <= in_cmd;
		end
		if (a_load) begin
			a_q <= mem_rdata;
		end
		if (b_load) begin
			b_q <= mem_rdata;
		end
	end

	// recent store shift line
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < RECENT_DEPTH; i++) begin
				recent_q[i] <= '0;
			end
		end else if (shift_en) begin
			recent_q[0] <= shift_word;
			for (int i = 1; i < RECENT_DEPTH; i++) begin
				recent_q[i] <= recent_q[i-1];
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			rv_q   <= out_rv;
			st_q   <= out_st;
			fill_q <= FILL_W'(cnt_nxt);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {fill_q, rv_q};
	assign m_tuser  = st_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(STACK_DEPTH))
		else $error("stack count beyond depth");

	a_out_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!m_tvalid_q || m_tready))
		else $error("result beat would overwrite a waiting one");

	a_busy_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !m_tvalid_q)
		else $error("result waiting while a command is in progress");

	a_swap_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RD2) |=> (state_q == S_WR2))
		else $error("swap write-back sequence broken");

	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		(s_fire && (in_cmd == CMD_PUSH) && !full) |=> (count_q == $past(count_q) + CW'(1)))
		else $error("push did not raise the count");
`endif

endmodule

`default_nettype wire

[design/osrc_ram.sv]
`default_nettype none

module osrc_ram #(
	parameter int DEPTH = 128,
	parameter int WIDTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     en,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// single port, registered read
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

`default_nettype wire
